### hdl/dijet_asymmetry_selector_core_assert.svh
// assertion macros shared by the dijet asymmetry selector rtl
`ifndef DIJET_ASYMMETRY_SELECTOR_CORE_ASSERT_SVH
`define DIJET_ASYMMETRY_SELECTOR_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define DAS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dijet selector assertion failed");

// next-cycle implication, clocked on clk_i, off during reset
`define DAS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dijet selector assertion failed");

`endif

### hdl/dasel_pkg.sv
// types and constants of the dijet asymmetry selector
package dasel_pkg;

  // default parameter values
  localparam int COUNT_BITS_DEF   = 32;
  localparam int AJ_FRAC_BITS_DEF = 10;

  // field widths
  localparam int AJ_W   = 12;
  localparam int HBIN_W = 7;
  localparam int PBIN_W = 6;

  // histogram bin counts
  localparam int TB_NBINS = 70;
  localparam int PX_NBINS = 35;
  localparam int PY_NBINS = 40;

  // register indexes
  localparam logic [1:0] CFG_PT_FLOOR    = 2'd0;
  localparam logic [1:0] CFG_LEAD_MIN    = 2'd1;
  localparam logic [1:0] CFG_SUBLEAD_MIN = 2'd2;
  localparam logic [1:0] CFG_DPHI_MIN    = 2'd3;

  // register reset values
  localparam logic [15:0] PT_FLOOR_RST    = 16'd16;
  localparam logic [15:0] LEAD_MIN_RST    = 16'd160;
  localparam logic [15:0] SUBLEAD_MIN_RST = 16'd80;
  localparam logic [15:0] DPHI_MIN_RST    = 16'd6431;

  // one jet entry
  typedef struct packed {
    logic        [31:0] event_id;
    logic        [15:0] truth_pt;
    logic        [15:0] reco_pt;
    logic signed [15:0] truth_phi;
    logic signed [15:0] reco_phi;
  } jet_t;

  // one closed-event result
  typedef struct packed {
    logic                     passed;
    logic signed [AJ_W-1:0]   aj_truth;
    logic signed [AJ_W-1:0]   aj_reco;
    logic        [HBIN_W-1:0] truth_bin;
    logic        [HBIN_W-1:0] reco_bin;
    logic        [PBIN_W-1:0] pair_bin_x;
    logic        [PBIN_W-1:0] pair_bin_y;
    logic        [31:0]       pass_total;
    logic        [31:0]       negative_total;
  } result_t;

endpackage

### hdl/dijet_asymmetry_selector_core.sv
// dijet asymmetry selector: jet pair tracking, event close and serial division
//
// Jet entries that stay in the open event are taken one per cycle. An entry with a
// new event number closes the open event and opens the new one in the same cycle;
// the block then stalls its input while the closed event is worked out. A failed
// event skips the divisions and goes straight to the output register load. A
// passing event runs six divisions (two asymmetries, four histogram bins) on one
// shared restoring divider that makes one quotient bit per cycle of an
// (AjFracBits+18)-bit numerator, with a load step before and a wrap-up step after
// each. The input stays stalled until the result is loaded into the output
// register; the next event may be worked out while that result waits there. The
// last event closes only when a later entry carries a different event number.
module dijet_asymmetry_selector_core #(
  parameter int CountBits  = dasel_pkg::COUNT_BITS_DEF,
  parameter int AjFracBits = dasel_pkg::AJ_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dasel_pkg::jet_t    in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dasel_pkg::result_t out_data_o
);

  localparam int NUM_W = AjFracBits + 18;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int One   = 1 << AjFracBits;
  localparam int AJ_W  = dasel_pkg::AJ_W;

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_DIV, S_POST} state_e;
  typedef enum logic [2:0] {OP_AT, OP_AR, OP_TB, OP_RB, OP_PX, OP_PY, OP_OUT} op_e;

  state_e state_q;
  op_e    op_q;

  // configuration registers
  logic [15:0] pt_floor_q, lead_min_q, sublead_min_q, dphi_min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_floor_q    <= dasel_pkg::PT_FLOOR_RST;
      lead_min_q    <= dasel_pkg::LEAD_MIN_RST;
      sublead_min_q <= dasel_pkg::SUBLEAD_MIN_RST;
      dphi_min_q    <= dasel_pkg::DPHI_MIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        dasel_pkg::CFG_PT_FLOOR:    pt_floor_q    <= cfg_wdata_i;
        dasel_pkg::CFG_LEAD_MIN:    lead_min_q    <= cfg_wdata_i;
        dasel_pkg::CFG_SUBLEAD_MIN: sublead_min_q <= cfg_wdata_i;
        default:                    dphi_min_q    <= cfg_wdata_i;
      endcase
    end
  end

  // open event state
  logic               have_q;
  logic [31:0]        cur_ev_q;
  logic [15:0]        lt_pt_q, st_pt_q, lr_pt_q, sr_pt_q;
  logic signed [15:0] lt_ph_q, st_ph_q, lr_ph_q, sr_ph_q;

  logic in_acc, closing, fresh, keep;
  assign in_stall_o = (state_q != S_IDLE) || (op_q == OP_OUT);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign closing    = in_acc && have_q && (in_data_i.event_id != cur_ev_q);
  assign fresh      = !have_q || closing;
  assign keep       = in_data_i.reco_pt >= pt_floor_q;

  // cuts on the open pair, evaluated when it closes
  logic signed [16:0] dt, dr;
  logic        [16:0] adt, adr;
  logic               pass_c;
  always_comb begin
    dt  = {lt_ph_q[15], lt_ph_q} - {st_ph_q[15], st_ph_q};
    dr  = {lr_ph_q[15], lr_ph_q} - {sr_ph_q[15], sr_ph_q};
    adt = dt[16] ? 17'(-dt) : 17'(dt);
    adr = dr[16] ? 17'(-dr) : 17'(dr);
    pass_c = (lt_pt_q > lead_min_q) && (st_pt_q > sublead_min_q) &&
             (adt > {1'b0, dphi_min_q}) && (lr_pt_q > lead_min_q) &&
             (sr_pt_q > sublead_min_q) && (adr > {1'b0, dphi_min_q});
  end

  // insertion of the new jet into the pair
  logic [15:0]        b_lt, b_st, b_lr, b_sr;
  logic signed [15:0] b_ltp, b_stp, b_lrp, b_srp;
  logic [15:0]        n_lt, n_st, n_lr, n_sr;
  logic signed [15:0] n_ltp, n_stp, n_lrp, n_srp;
  always_comb begin
    b_lt  = fresh ? 16'd0 : lt_pt_q;
    b_st  = fresh ? 16'd0 : st_pt_q;
    b_lr  = fresh ? 16'd0 : lr_pt_q;
    b_sr  = fresh ? 16'd0 : sr_pt_q;
    b_ltp = fresh ? 16'sd0 : lt_ph_q;
    b_stp = fresh ? 16'sd0 : st_ph_q;
    b_lrp = fresh ? 16'sd0 : lr_ph_q;
    b_srp = fresh ? 16'sd0 : sr_ph_q;
    n_lt = b_lt; n_st = b_st; n_lr = b_lr; n_sr = b_sr;
    n_ltp = b_ltp; n_stp = b_stp; n_lrp = b_lrp; n_srp = b_srp;
    priority if (keep && (in_data_i.truth_pt > b_lt)) begin
      n_st = b_lt; n_lt = in_data_i.truth_pt;
      n_sr = b_lr; n_lr = in_data_i.reco_pt;
      n_stp = b_ltp; n_ltp = in_data_i.truth_phi;
      n_srp = b_lrp; n_lrp = in_data_i.reco_phi;
    end else if (keep && (in_data_i.truth_pt > b_st)) begin
      n_st = in_data_i.truth_pt; n_sr = in_data_i.reco_pt;
      n_stp = in_data_i.truth_phi; n_srp = in_data_i.reco_phi;
    end else begin
      n_lt = b_lt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q   <= 1'b0;
      cur_ev_q <= '0;
      lt_pt_q  <= '0; st_pt_q <= '0; lr_pt_q <= '0; sr_pt_q <= '0;
      lt_ph_q  <= '0; st_ph_q <= '0; lr_ph_q <= '0; sr_ph_q <= '0;
    end else if (in_acc) begin
      have_q   <= 1'b1;
      cur_ev_q <= in_data_i.event_id;
      lt_pt_q  <= n_lt;  st_pt_q <= n_st;  lr_pt_q <= n_lr;  sr_pt_q <= n_sr;
      lt_ph_q  <= n_ltp; st_ph_q <= n_stp; lr_ph_q <= n_lrp; sr_ph_q <= n_srp;
    end
  end

  // running counters, bumped when a passing event closes
  logic [CountBits-1:0] pass_cnt_q, neg_cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_cnt_q <= '0;
      neg_cnt_q  <= '0;
    end else if (closing && pass_c) begin
      if (pass_cnt_q != '1) pass_cnt_q <= pass_cnt_q + 1'b1;
      if ((lr_pt_q < sr_pt_q) && (neg_cnt_q != '1)) neg_cnt_q <= neg_cnt_q + 1'b1;
    end
  end

  // snapshot of the closed pair
  logic [15:0] sn_lt_q, sn_st_q, sn_lr_q, sn_sr_q;
  logic        sn_pass_q;
  always_ff @(posedge clk_i) begin
    if (closing) begin
      sn_lt_q   <= lt_pt_q;
      sn_st_q   <= st_pt_q;
      sn_lr_q   <= lr_pt_q;
      sn_sr_q   <= sr_pt_q;
      sn_pass_q <= pass_c;
    end
  end

  // results of the passed-event divisions
  logic signed [AJ_W-1:0]              at_q, ar_q;
  logic [dasel_pkg::HBIN_W-1:0]        tb_q, rb_q;
  logic [dasel_pkg::PBIN_W-1:0]        px_q, py_q;

  // divider operands for the current operation
  logic [15:0]              p_lead, p_sub;
  logic [16:0]              p_sum, p_mag;
  logic signed [AJ_W-1:0]   p_aj;
  logic signed [NUM_W:0]    aj_x, bnum;
  logic [NUM_W-1:0]         ld_num, ld_den;
  logic                     ld_neg;
  logic [dasel_pkg::HBIN_W-1:0] nb;
  always_comb begin
    p_lead = (op_q == OP_AT) ? sn_lt_q : sn_lr_q;
    p_sub  = (op_q == OP_AT) ? sn_st_q : sn_sr_q;
    p_sum  = {1'b0, p_lead} + {1'b0, p_sub};
    p_mag  = (p_lead >= p_sub) ? ({1'b0, p_lead} - {1'b0, p_sub})
                               : ({1'b0, p_sub} - {1'b0, p_lead});
    p_aj   = ((op_q == OP_TB) || (op_q == OP_PX)) ? at_q : ar_q;
    aj_x   = {{(NUM_W + 1 - AJ_W){p_aj[AJ_W-1]}}, p_aj};
    bnum   = '0;
    ld_den = NUM_W'(27 * One);
    nb     = dasel_pkg::HBIN_W'(dasel_pkg::TB_NBINS);
    unique case (op_q)
      OP_TB, OP_RB: begin
        bnum   = (NUM_W + 1)'((aj_x * 100 + 35 * One) * 14);
        ld_den = NUM_W'(27 * One);
        nb     = dasel_pkg::HBIN_W'(dasel_pkg::TB_NBINS);
      end
      OP_PX: begin
        bnum   = (NUM_W + 1)'(aj_x * 175);
        ld_den = NUM_W'(4 * One);
        nb     = dasel_pkg::HBIN_W'(dasel_pkg::PX_NBINS);
      end
      OP_PY: begin
        bnum   = (NUM_W + 1)'((aj_x * 10 + 5 * One) * 40);
        ld_den = NUM_W'(13 * One);
        nb     = dasel_pkg::HBIN_W'(dasel_pkg::PY_NBINS);
      end
      default: begin
        ld_den = NUM_W'({p_sum, 1'b0});
      end
    endcase
    if ((op_q == OP_AT) || (op_q == OP_AR)) begin
      ld_num = NUM_W'({p_mag, (AjFracBits + 1)'(0)}) + NUM_W'(p_sum);
      ld_neg = p_lead < p_sub;
    end else begin
      ld_neg = bnum[NUM_W];
      ld_num = ld_neg ? '0 : bnum[NUM_W-1:0];
    end
  end

  // one restoring division step
  logic [NUM_W-1:0] n_q, r_q, den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             neg_q;
  logic [NUM_W:0]   rem_ext, rem_new;
  logic             qbit;
  always_comb begin
    rem_ext = {r_q, n_q[NUM_W-1]};
    qbit    = rem_ext >= {1'b0, den_q};
    rem_new = qbit ? (rem_ext - {1'b0, den_q}) : rem_ext;
  end

  // wrap-up of a finished quotient
  logic signed [AJ_W-1:0]       post_aj;
  logic [dasel_pkg::HBIN_W-1:0] post_bin;
  logic                         q_over;
  always_comb begin
    if (neg_q) begin
      post_aj = (n_q > NUM_W'(2048)) ? AJ_W'(12'h800) : AJ_W'(12'd0 - n_q[11:0]);
    end else begin
      post_aj = (n_q > NUM_W'(2047)) ? AJ_W'(12'h7FF) : n_q[AJ_W-1:0];
    end
    q_over = n_q >= NUM_W'(nb);
    if (neg_q) begin
      post_bin = '0;
    end else if (q_over) begin
      post_bin = nb + 1'b1;
    end else begin
      post_bin = n_q[dasel_pkg::HBIN_W-1:0] + 1'b1;
    end
  end

  // output register load
  logic               out_valid_q;
  logic               out_load;
  dasel_pkg::result_t out_q, res_c;
  logic [63:0]        pass_w, neg_w;
  assign out_load = (op_q == OP_OUT) && (!out_valid_q || !out_stall_i);
  always_comb begin
    pass_w = 64'(pass_cnt_q);
    neg_w  = 64'(neg_cnt_q);
    res_c.passed         = sn_pass_q;
    res_c.aj_truth       = sn_pass_q ? at_q : '0;
    res_c.aj_reco        = sn_pass_q ? ar_q : '0;
    res_c.truth_bin      = sn_pass_q ? tb_q : '0;
    res_c.reco_bin       = sn_pass_q ? rb_q : '0;
    res_c.pair_bin_x     = sn_pass_q ? px_q : '0;
    res_c.pair_bin_y     = sn_pass_q ? py_q : '0;
    res_c.pass_total     = (pass_w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pass_w[31:0];
    res_c.negative_total = (neg_w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : neg_w[31:0];
  end

  // close sequencer, divider and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_AT;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      r_q         <= '0;
      den_q       <= '0;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      at_q        <= '0;
      ar_q        <= '0;
      tb_q        <= '0;
      rb_q        <= '0;
      px_q        <= '0;
      py_q        <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        op_q        <= OP_AT;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (closing) begin
            if (pass_c) begin
              state_q <= S_LOAD;
              op_q    <= OP_AT;
            end else begin
              op_q    <= OP_OUT;
            end
          end
        end
        S_LOAD: begin
          n_q     <= ld_num;
          den_q   <= ld_den;
          neg_q   <= ld_neg;
          r_q     <= '0;
          cnt_q   <= CNT_W'(NUM_W - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          n_q   <= {n_q[NUM_W-2:0], qbit};
          r_q   <= rem_new[NUM_W-1:0];
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) state_q <= S_POST;
        end
        default: begin
          state_q <= S_LOAD;
          unique case (op_q)
            OP_AT: begin at_q <= post_aj; op_q <= OP_AR; end
            OP_AR: begin ar_q <= post_aj; op_q <= OP_TB; end
            OP_TB: begin tb_q <= post_bin; op_q <= OP_RB; end
            OP_RB: begin rb_q <= post_bin; op_q <= OP_PX; end
            OP_PX: begin
              px_q <= post_bin[dasel_pkg::PBIN_W-1:0];
              op_q <= OP_PY;
            end
            default: begin
              py_q    <= post_bin[dasel_pkg::PBIN_W-1:0];
              op_q    <= OP_OUT;
              state_q <= S_IDLE;
            end
          endcase
        end
      endcase
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= res_c;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `include "dijet_asymmetry_selector_core_assert.svh"

  `DAS_ASSERT_NOW(a_neg_le_pass, 1'b1, neg_cnt_q <= pass_cnt_q)
  `DAS_ASSERT_NEXT(a_close_busy, closing, in_stall_o)
  `DAS_ASSERT_NEXT(a_div_done, (state_q == S_DIV) && (cnt_q == '0), state_q == S_POST)
  `DAS_ASSERT_NEXT(a_load_sets_valid, out_load, out_valid_q)

endmodule

### tb/dijet_event_checker.sv
// channel monitor, dijet event predictor and result comparison for the selector
module dijet_event_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  dasel_pkg::jet_t    in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  dasel_pkg::result_t out_data_i,
  output int                 fail_count_o,
  output int                 pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     AJ_W   = dasel_pkg::AJ_W;
  localparam int     HBIN_W = dasel_pkg::HBIN_W;
  localparam int     PBIN_W = dasel_pkg::PBIN_W;
  localparam int     FRAC   = dasel_pkg::AJ_FRAC_BITS_DEF;
  localparam longint AJ_ONE = longint'(1) << FRAC;

  // cut registers as last written
  logic [15:0] floor_cut, lead_cut, sub_cut, dphi_cut;

  // open event and its two leading jets
  logic               open_event;
  logic [31:0]        open_id;
  logic [15:0]        lt_pt, st_pt, lr_pt, sr_pt;
  logic signed [15:0] lt_phi, st_phi, lr_phi, sr_phi;

  // running selection counters
  logic [31:0] passed_so_far, negative_so_far;

  dasel_pkg::result_t expected_q[$];
  int                 fails;

  // asymmetry in fixed point, rounded half away from zero
  function automatic logic signed [AJ_W-1:0] round_asym(logic [15:0] lead,
                                                         logic [15:0] sub);
    longint diff, total, mag, q;
    diff = longint'(lead) - longint'(sub);
    total = longint'(lead) + longint'(sub);
    if (total == 0) return '0;
    mag = (diff < 0 ? -diff : diff) << FRAC;
    q = (2 * mag + total) / (2 * total);
    if (diff < 0) q = -q;
    if (q > 2047) q = 2047;
    if (q < -2048) q = -2048;
    return AJ_W'(q);
  endfunction

  // histogram index with underflow at zero and overflow at nbins+1
  function automatic longint bin_of(longint num, longint den, longint nbins);
    if (num < 0) return 0;
    if (num / den >= nbins) return nbins + 1;
    return num / den + 1;
  endfunction

  task automatic forget_jets();
    lt_pt = '0;
    st_pt = '0;
    lr_pt = '0;
    sr_pt = '0;
    lt_phi = '0;
    st_phi = '0;
    lr_phi = '0;
    sr_phi = '0;
  endtask

  task automatic check_field(string name, longint want_v, longint got_v);
    if (want_v != got_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dasel_pkg::result_t want;
    dasel_pkg::result_t got;
    dasel_pkg::jet_t    jet;
    int                 dt, dr;
    longint             at, ar;
    logic               cuts_met;
    if (!rst_ni) begin
      floor_cut = dasel_pkg::PT_FLOOR_RST;
      lead_cut = dasel_pkg::LEAD_MIN_RST;
      sub_cut = dasel_pkg::SUBLEAD_MIN_RST;
      dphi_cut = dasel_pkg::DPHI_MIN_RST;
      open_event = 1'b0;
      open_id = '0;
      forget_jets();
      passed_so_far = '0;
      negative_so_far = '0;
      expected_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_count_o <= 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_addr_i)
          dasel_pkg::CFG_PT_FLOOR:    floor_cut = cfg_wdata_i;
          dasel_pkg::CFG_LEAD_MIN:    lead_cut = cfg_wdata_i;
          dasel_pkg::CFG_SUBLEAD_MIN: sub_cut = cfg_wdata_i;
          dasel_pkg::CFG_DPHI_MIN:    dphi_cut = cfg_wdata_i;
          default: ;
        endcase
      end

      // delivered result against the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (expected_q.size() == 0) begin
          $error("result delivered while no closed event is pending");
          fails++;
        end else begin
          want = expected_q.pop_front();
          check_field("passed", want.passed, got.passed);
          check_field("aj_truth", $signed(want.aj_truth), $signed(got.aj_truth));
          check_field("aj_reco", $signed(want.aj_reco), $signed(got.aj_reco));
          check_field("truth_bin", want.truth_bin, got.truth_bin);
          check_field("reco_bin", want.reco_bin, got.reco_bin);
          check_field("pair_bin_x", want.pair_bin_x, got.pair_bin_x);
          check_field("pair_bin_y", want.pair_bin_y, got.pair_bin_y);
          check_field("pass_total", want.pass_total, got.pass_total);
          check_field("negative_total", want.negative_total, got.negative_total);
        end
      end

      // accepted jet request
      if (in_valid_i && !in_stall_i) begin
        jet = in_data_i;

        // a new event number closes the open event
        if (open_event && jet.event_id != open_id) begin
          dt = int'(lt_phi) - int'(st_phi);
          dr = int'(lr_phi) - int'(sr_phi);
          if (dt < 0) dt = -dt;
          if (dr < 0) dr = -dr;
          cuts_met = lt_pt > lead_cut && st_pt > sub_cut && dt > int'(dphi_cut) &&
                     lr_pt > lead_cut && sr_pt > sub_cut && dr > int'(dphi_cut);
          want = '0;
          if (cuts_met) begin
            at = round_asym(lt_pt, st_pt);
            ar = round_asym(lr_pt, sr_pt);
            want.passed = 1'b1;
            want.aj_truth = AJ_W'(at);
            want.aj_reco = AJ_W'(ar);
            want.truth_bin = HBIN_W'(bin_of((100 * at + 35 * AJ_ONE) * 14, 27 * AJ_ONE,
                                            dasel_pkg::TB_NBINS));
            want.reco_bin = HBIN_W'(bin_of((100 * ar + 35 * AJ_ONE) * 14, 27 * AJ_ONE,
                                           dasel_pkg::TB_NBINS));
            want.pair_bin_x = PBIN_W'(bin_of(175 * at, 4 * AJ_ONE, dasel_pkg::PX_NBINS));
            want.pair_bin_y = PBIN_W'(bin_of((10 * ar + 5 * AJ_ONE) * 40, 13 * AJ_ONE,
                                             dasel_pkg::PY_NBINS));
            if (passed_so_far != '1) passed_so_far++;
            // exact sign of the reco pair, not the rounded asymmetry
            if (lr_pt < sr_pt && negative_so_far != '1) negative_so_far++;
          end
          want.pass_total = passed_so_far;
          want.negative_total = negative_so_far;
          expected_q.push_back(want);
        end

        // the closing entry opens the next event
        if (!open_event || jet.event_id != open_id) begin
          open_event = 1'b1;
          open_id = jet.event_id;
          forget_jets();
        end

        // rank by truth pt, ties keep the older jet
        if (jet.reco_pt >= floor_cut) begin
          if (jet.truth_pt > lt_pt) begin
            st_pt = lt_pt;
            lt_pt = jet.truth_pt;
            sr_pt = lr_pt;
            lr_pt = jet.reco_pt;
            st_phi = lt_phi;
            lt_phi = jet.truth_phi;
            sr_phi = lr_phi;
            lr_phi = jet.reco_phi;
          end else if (jet.truth_pt > st_pt) begin
            st_pt = jet.truth_pt;
            sr_pt = jet.reco_pt;
            st_phi = jet.truth_phi;
            sr_phi = jet.reco_phi;
          end
        end
      end

      fail_count_o <= fails;
      pending_count_o <= expected_q.size();
    end
  end

endmodule

### tb/dijet_asymmetry_selector_core_tb.sv
// stimulus and verdict for the dijet asymmetry selector core
module dijet_asymmetry_selector_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES   = 400;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_addr = dasel_pkg::CFG_PT_FLOOR;
  logic [15:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  dasel_pkg::jet_t    in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  dasel_pkg::result_t out_data;

  int          fail_count;
  int          pending_count;
  int          cycle_count = 0;

  // pacing and phase bookkeeping
  bit          feed_burst = 1'b0;
  bit          drain_burst = 1'b0;
  bit          result_hold_req = 1'b0;
  logic [31:0] event_seq = 32'd100;
  int          sent_items = 0;

  dijet_asymmetry_selector_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_addr_i (cfg_addr),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  dijet_event_checker event_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_data_i     (out_data),
    .fail_count_o   (fail_count),
    .pending_count_o(pending_count)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic dasel_pkg::jet_t mk_jet(logic [31:0] ev, int tpt, int rpt, int tphi,
                                             int rphi);
    dasel_pkg::jet_t j;
    j.event_id = ev;
    j.truth_pt = 16'(tpt);
    j.reco_pt = 16'(rpt);
    j.truth_phi = 16'(tphi);
    j.reco_phi = 16'(rphi);
    return j;
  endfunction

  // pt spread over the full range, the cut region and the top end
  function automatic logic [15:0] pick_pt();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 400));
      2:       return 16'($urandom_range(60, 260));
      default: return 16'($urandom_range(65000, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_phi();
    if ($urandom_range(0, 1) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 16383) - 8192);
  endfunction

  // one jet request with a random lead-in gap
  task automatic send_jet(dasel_pkg::jet_t jet);
    int gap;
    gap = feed_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= jet;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // all four cut registers, back to back
  task automatic load_cuts(logic [15:0] floor_v, logic [15:0] lead_v,
                           logic [15:0] sub_v, logic [15:0] dphi_v);
    cfg_we <= 1'b1;
    cfg_addr <= dasel_pkg::CFG_PT_FLOOR;
    cfg_wdata <= floor_v;
    @(posedge clk);
    cfg_addr <= dasel_pkg::CFG_LEAD_MIN;
    cfg_wdata <= lead_v;
    @(posedge clk);
    cfg_addr <= dasel_pkg::CFG_SUBLEAD_MIN;
    cfg_wdata <= sub_v;
    @(posedge clk);
    cfg_addr <= dasel_pkg::CFG_DPHI_MIN;
    cfg_wdata <= dphi_v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // stop feeding, wait for every closed event, then let the divider go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed multi-jet events, some stray and repeated numbers
  task automatic send_random_event();
    int              kind;
    int              njets;
    logic [31:0]     id;
    logic [15:0]     prev_truth;
    dasel_pkg::jet_t jet;
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      id = $urandom;
      njets = 1;
    end else if (kind == 2) begin
      id = event_seq - 1;
      njets = $urandom_range(1, 2);
    end else begin
      event_seq++;
      id = event_seq;
      njets = $urandom_range(1, 5);
    end
    prev_truth = '0;
    for (int j = 0; j < njets; j++) begin
      jet.event_id = id;
      jet.truth_pt = pick_pt();
      if (j > 0 && $urandom_range(0, 7) == 0) jet.truth_pt = prev_truth;
      jet.reco_pt = pick_pt();
      jet.truth_phi = pick_phi();
      jet.reco_phi = pick_phi();
      prev_truth = jet.truth_pt;
      sent_items++;
      send_jet(jet);
    end
  endtask

  task automatic run_random(int count);
    int target;
    target = sent_items + count;
    while (sent_items < target) begin
      send_random_event();
      if ($urandom_range(0, 29) == 0) feed_burst = !feed_burst;
    end
  endtask

  // result side: random stalls, bursts without stalls, one long hold-off on request
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (result_hold_req) begin
        result_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = drain_burst ? 0 : $urandom_range(0, 18);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if ($urandom_range(0, 24) == 0) drain_burst = !drain_burst;
    end
  end

  // reset, phases of cut settings, verdict
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    load_cuts(dasel_pkg::PT_FLOOR_RST, dasel_pkg::LEAD_MIN_RST,
              dasel_pkg::SUBLEAD_MIN_RST, dasel_pkg::DPHI_MIN_RST);

    // first entry after reset only opens; tie and below-floor jets
    send_jet(mk_jet(32'd0, 2000, 2000, 0, 0));
    send_jet(mk_jet(32'd0, 1000, 1500, 13000, 13000));
    send_jet(mk_jet(32'd0, 1000, 900, -5000, -5000));
    send_jet(mk_jet(32'd0, 60000, 15, 0, 0));
    // passing event, then a negative one at the widest phi gap
    send_jet(mk_jet(32'd1, 300, 800, -32768, -32768));
    send_jet(mk_jet(32'd1, 500, 200, 32767, 32767));
    // top event number, empty subleader
    send_jet(mk_jet(32'hFFFF_FFFF, 65535, 65535, 0, 0));
    send_jet(mk_jet(32'hFFFF_FFFF, 0, 65535, 1000, 1000));
    // event with no counted jet, zero pt sums
    send_jet(mk_jet(32'd2, 100, 0, 5, 5));
    // phi gap equal to the cut
    send_jet(mk_jet(32'd3, 200, 200, 100, 100));
    send_jet(mk_jet(32'd3, 150, 150, 6531, 6531));
    // one above every cut
    send_jet(mk_jet(32'd4, 161, 161, 0, 0));
    send_jet(mk_jet(32'd4, 81, 81, 6432, -6432));
    // leader equal to the cut
    send_jet(mk_jet(32'd5, 160, 5000, 0, 0));
    send_jet(mk_jet(32'd5, 100, 3000, 20000, 20000));
    // equal truth pt; reco slightly negative, rounds to zero
    send_jet(mk_jet(32'd6, 1000, 60000, 0, 0));
    send_jet(mk_jet(32'd6, 1000, 60001, 8000, 8000));
    // asymmetry near one, overflow bins
    send_jet(mk_jet(32'd7, 60000, 60000, 0, 0));
    send_jet(mk_jet(32'd7, 81, 90, -10000, -10000));
    // truth positive, reco negative; jet at the floor that does not rank
    send_jet(mk_jet(32'd8, 300, 200, 0, 0));
    send_jet(mk_jet(32'd8, 290, 250, 7000, 7000));
    send_jet(mk_jet(32'd8, 10, 16, 3000, 3000));
    send_jet(mk_jet(32'd9, 500, 500, 0, 0));

    run_random(100);
    settle();

    // everything open
    load_cuts('0, '0, '0, '0);
    run_random(110);
    settle();

    // everything closed
    load_cuts('1, '1, '1, '1);
    run_random(70);
    settle();

    // random cuts near the data
    load_cuts(16'($urandom_range(0, 300)), 16'($urandom_range(0, 3000)),
              16'($urandom_range(0, 1500)), 16'($urandom_range(0, 25000)));
    run_random(110);
    settle();
    load_cuts(16'($urandom_range(0, 300)), 16'($urandom_range(0, 3000)),
              16'($urandom_range(0, 1500)), 16'($urandom_range(0, 25000)));
    run_random(80);
    settle();

    // defaults with a long result hold-off while jets keep coming
    load_cuts(dasel_pkg::PT_FLOOR_RST, dasel_pkg::LEAD_MIN_RST,
              dasel_pkg::SUBLEAD_MIN_RST, dasel_pkg::DPHI_MIN_RST);
    feed_burst = 1'b1;
    result_hold_req = 1'b1;
    run_random(130);
    settle();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
